// ----- rtl/cbpt_pkg.sv -----
// ---------------------------------------------------------------------------
// cbpt_pkg: shared types and constants for the cubic Bezier evaluator
// Field widths, the unit parameter value and the pipeline depth.
// ---------------------------------------------------------------------------
package cbpt_pkg;

   localparam int COORD_BITS      = 24;
   localparam int PARAM_FRAC_BITS = 16;
   localparam int PARAM_BITS      = PARAM_FRAC_BITS + 1;
   localparam int SLOPE_BITS      = COORD_BITS + 3;

   // Register stages from the input register to the output register.
   localparam int STAGES = 7;

   typedef logic signed [COORD_BITS-1:0] coord_type;
   typedef logic signed [SLOPE_BITS-1:0] slope_type;
   typedef logic        [PARAM_BITS-1:0] param_type;

   localparam param_type T_ONE = param_type'(1) << PARAM_FRAC_BITS;

endpackage

// ----- rtl/cbpt_axis.sv -----
// ---------------------------------------------------------------------------
// cbpt_axis: one coordinate axis of the Bezier evaluator
// Seven-stage Horner datapath giving the rounded point and derivative for
// one axis. All stages advance together when the enable is high.
// ---------------------------------------------------------------------------
module cbpt_axis (
   input  logic                clock,
   input  logic                enable,
   input  cbpt_pkg::coord_type p0,
   input  cbpt_pkg::coord_type p1,
   input  cbpt_pkg::coord_type p2,
   input  cbpt_pkg::coord_type p3,
   input  cbpt_pkg::param_type param_t,
   output cbpt_pkg::coord_type point,
   output cbpt_pkg::slope_type slope
);
   import cbpt_pkg::*;

   // Stage 0: polynomial coefficients.
   logic signed [28:0] w0, w1, w2, w3, d10, s2, d12, c1w, c2w, c3w;
   logic signed [26:0] c1_0_ff, c3_0_ff;
   logic signed [27:0] c2_0_ff;
   coord_type          p0_0_ff;
   param_type          t0_ff;

   // Stage 1: c3 * t.
   logic signed [17:0] ts0;
   logic signed [44:0] m1_in, m1_ff;
   logic signed [26:0] c1_1_ff;
   logic signed [27:0] c2_1_ff;
   coord_type          p0_1_ff;
   param_type          t1_ff;

   // Stage 2: first Horner sums for point and slope.
   logic signed [45:0] a1_in, a1_ff;
   logic signed [46:0] b1_in, b1_ff;
   logic signed [26:0] c1_2_ff;
   coord_type          p0_2_ff;
   param_type          t2_ff;

   // Stage 3: partial products of the second multiply.
   logic signed [17:0] ts2;
   logic signed [47:0] pah_in, pah_ff;
   logic signed [48:0] pbh_in, pbh_ff;
   logic        [32:0] pal_in, pal_ff, pbl_in, pbl_ff;
   logic signed [26:0] c1_3_ff;
   coord_type          p0_3_ff;
   param_type          t3_ff;

   // Stage 4: second Horner sums.
   logic signed [61:0] a2_in, a2_ff, b2_in, b2_ff;
   coord_type          p0_4_ff;
   param_type          t4_ff;

   // Stage 5: partial products of the third multiply, slope rounding.
   logic signed [17:0] ts4;
   logic signed [47:0] ph_in, ph_ff;
   logic        [32:0] pm_in, pm_ff, pl_in, pl_ff;
   logic signed [61:0] b2_rnd;
   slope_type          slope5_ff;
   coord_type          p0_5_ff;

   // Stage 6: final sum and point rounding.
   logic signed [71:0] a3;
   coord_type          point_ff;
   slope_type          slope_ff;

   always_comb begin
      w0  = 29'(p0);
      w1  = 29'(p1);
      w2  = 29'(p2);
      w3  = 29'(p3);
      d10 = w1 - w0;
      c1w = d10 + (d10 <<< 1);
      s2  = w0 - (w1 <<< 1) + w2;
      c2w = s2 + (s2 <<< 1);
      d12 = w1 - w2;
      c3w = w3 - w0 + d12 + (d12 <<< 1);
   end

   assign ts0   = $signed({1'b0, t0_ff});
   assign m1_in = 45'(c3_0_ff) * 45'(ts0);

   assign a1_in = 46'(m1_ff) + (46'(c2_1_ff) <<< 16);
   assign b1_in = (47'(m1_ff) <<< 1) + 47'(m1_ff) + (47'(c2_1_ff) <<< 17);

   assign ts2    = $signed({1'b0, t2_ff});
   assign pah_in = 48'($signed(a1_ff[45:16])) * 48'(ts2);
   assign pbh_in = 49'($signed(b1_ff[46:16])) * 49'(ts2);
   assign pal_in = 33'(a1_ff[15:0]) * 33'(t2_ff);
   assign pbl_in = 33'(b1_ff[15:0]) * 33'(t2_ff);

   assign a2_in = (62'(pah_ff) <<< 16) + 62'(pal_ff) + (62'(c1_3_ff) <<< 32);
   assign b2_in = (62'(pbh_ff) <<< 16) + 62'(pbl_ff) + (62'(c1_3_ff) <<< 32);

   assign ts4    = $signed({1'b0, t4_ff});
   assign ph_in  = 48'($signed(a2_ff[61:32])) * 48'(ts4);
   assign pm_in  = 33'(a2_ff[31:16]) * 33'(t4_ff);
   assign pl_in  = 33'(a2_ff[15:0]) * 33'(t4_ff);
   // Adding one half before the arithmetic shift rounds ties upward.
   assign b2_rnd = b2_ff + (62'sd1 <<< 31);

   assign a3 = (72'(ph_ff) <<< 32) + (72'(pm_ff) << 16) + 72'(pl_ff)
             + (72'(p0_5_ff) <<< 48) + (72'sd1 <<< 47);

   always_ff @(posedge clock) begin
      if (enable) begin
         c1_0_ff   <= c1w[26:0];
         c2_0_ff   <= c2w[27:0];
         c3_0_ff   <= c3w[26:0];
         p0_0_ff   <= p0;
         t0_ff     <= param_t;

         m1_ff     <= m1_in;
         c1_1_ff   <= c1_0_ff;
         c2_1_ff   <= c2_0_ff;
         p0_1_ff   <= p0_0_ff;
         t1_ff     <= t0_ff;

         a1_ff     <= a1_in;
         b1_ff     <= b1_in;
         c1_2_ff   <= c1_1_ff;
         p0_2_ff   <= p0_1_ff;
         t2_ff     <= t1_ff;

         pah_ff    <= pah_in;
         pbh_ff    <= pbh_in;
         pal_ff    <= pal_in;
         pbl_ff    <= pbl_in;
         c1_3_ff   <= c1_2_ff;
         p0_3_ff   <= p0_2_ff;
         t3_ff     <= t2_ff;

         a2_ff     <= a2_in;
         b2_ff     <= b2_in;
         p0_4_ff   <= p0_3_ff;
         t4_ff     <= t3_ff;

         ph_ff     <= ph_in;
         pm_ff     <= pm_in;
         pl_ff     <= pl_in;
         slope5_ff <= b2_rnd[58:32];
         p0_5_ff   <= p0_4_ff;

         point_ff  <= a3[71:48];
         slope_ff  <= slope5_ff;
      end
   end

   assign point = point_ff;
   assign slope = slope_ff;

endmodule

// ----- rtl/cubic_bezier_point_tangent.sv -----
// ---------------------------------------------------------------------------
// cubic_bezier_point_tangent: cubic Bezier point and derivative evaluator
// Evaluates a 2-D cubic Bezier curve and its first derivative at t,
// rounded to nearest: the point in signed Q16.8, the derivative in signed Q19.8.
// ---------------------------------------------------------------------------
//   Channel   Direction   Beat contents
//   req_      in          four control points (x, y) and param_t
//   rsp_      out         point_x, point_y, slope_x, slope_y
//
// One beat is accepted per cycle while req_stall is low; a result passes
// through seven register stages: the coefficient stage and then three Horner
// multiply steps, each split into a product stage and a sum stage.
// The block holds no state; reset only clears the stage valid bits.
// A stalled result freezes the whole pipeline, so req_stall follows rsp_stall
// while the output register holds a beat.
// ---------------------------------------------------------------------------
module cubic_bezier_point_tangent (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  cbpt_pkg::coord_type req_ctrl0_x,
   input  cbpt_pkg::coord_type req_ctrl0_y,
   input  cbpt_pkg::coord_type req_ctrl1_x,
   input  cbpt_pkg::coord_type req_ctrl1_y,
   input  cbpt_pkg::coord_type req_ctrl2_x,
   input  cbpt_pkg::coord_type req_ctrl2_y,
   input  cbpt_pkg::coord_type req_ctrl3_x,
   input  cbpt_pkg::coord_type req_ctrl3_y,
   input  cbpt_pkg::param_type req_param_t,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output cbpt_pkg::coord_type rsp_point_x,
   output cbpt_pkg::coord_type rsp_point_y,
   output cbpt_pkg::slope_type rsp_slope_x,
   output cbpt_pkg::slope_type rsp_slope_y
);
   import cbpt_pkg::*;

   logic              pipe_en;
   logic [STAGES-1:0] vld_ff, vld_in;
   param_type         t_sat;

   assign pipe_en   = !(vld_ff[STAGES-1] && rsp_stall);
   assign req_stall = !pipe_en;
   assign rsp_valid = vld_ff[STAGES-1];

   // A parameter above one is held at one.
   assign t_sat  = (req_param_t > T_ONE) ? T_ONE : req_param_t;
   assign vld_in = {vld_ff[STAGES-2:0], req_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (pipe_en) begin
         vld_ff <= vld_in;
      end
   end

   cbpt_axis u_axis_x (
      .clock   (clock),
      .enable  (pipe_en),
      .p0      (req_ctrl0_x),
      .p1      (req_ctrl1_x),
      .p2      (req_ctrl2_x),
      .p3      (req_ctrl3_x),
      .param_t (t_sat),
      .point   (rsp_point_x),
      .slope   (rsp_slope_x)
   );

   cbpt_axis u_axis_y (
      .clock   (clock),
      .enable  (pipe_en),
      .p0      (req_ctrl0_y),
      .p1      (req_ctrl1_y),
      .p2      (req_ctrl2_y),
      .p3      (req_ctrl3_y),
      .param_t (t_sat),
      .point   (rsp_point_y),
      .slope   (rsp_slope_y)
   );

   // An accepted request beat must occupy the first stage next cycle.
   a_accept_enters: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> vld_ff[0])
      else $error("accepted request beat did not enter the pipeline");

   // A frozen pipeline keeps every valid bit and the waiting x point and y slope.
   a_freeze_holds: assert property (@(posedge clock) disable iff (reset)
      !pipe_en |=> ($stable(vld_ff) && $stable(rsp_point_x) && $stable(rsp_slope_y)))
      else $error("pipeline moved while the result was stalled");

   // A taken result with nothing behind it leaves the output empty.
   a_drain: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && !vld_ff[STAGES-2]) |=> !rsp_valid)
      else $error("result beat repeated after it was taken");

   // Reset empties every stage.
   a_reset_clears: assert property (@(posedge clock)
      reset |=> (vld_ff == '0))
      else $error("stage valid bits not cleared by reset");

endmodule
